/* src/uart_tx_pkg.sv */
`timescale 1ns / 1ps

package uart_tx_pkg;

  // Frame: start, up to 8 data bits, optional parity, stop
  localparam int unsigned FrameWidth = 11;
  localparam int unsigned CountWidth = 4;
  localparam int unsigned ByteWidth  = 8;

  // Configuration register indexes
  localparam int unsigned CfgIndexWidth = 2;
  localparam logic [CfgIndexWidth-1:0] CFG_BIT_PERIOD  = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_DATA_BITS   = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_PARITY_MODE = 2'd2;

  localparam int unsigned DataBitsWidth = 4;
  localparam int unsigned ParityWidth   = 3;

  localparam logic [DataBitsWidth-1:0] DATA_BITS_MIN   = 4'd5;
  localparam logic [DataBitsWidth-1:0] DATA_BITS_MAX   = 4'd8;
  localparam logic [DataBitsWidth-1:0] DATA_BITS_RESET = 4'd8;

  // Parity modes
  localparam logic [ParityWidth-1:0] PAR_NONE   = 3'd0;
  localparam logic [ParityWidth-1:0] PAR_EVEN   = 3'd1;
  localparam logic [ParityWidth-1:0] PAR_ODD    = 3'd2;
  localparam logic [ParityWidth-1:0] PAR_MARK   = 3'd3;
  localparam logic [ParityWidth-1:0] PAR_SPACE  = 3'd4;

  // Input actions
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

endpackage

/* src/uart_tx_in_if.sv */
`timescale 1ns / 1ps

interface uart_tx_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] tx_byte;

  modport source (output valid, output action, output tx_byte, input ready);
  modport sink   (input valid, input action, input tx_byte, output ready);
endinterface

/* src/uart_tx_out_if.sv */
`timescale 1ns / 1ps

interface uart_tx_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic load_refused;

  modport source (output valid, output line_level, output busy_res, output load_refused,
                  input ready);
  modport sink   (input valid, input line_level, input busy_res, input load_refused,
                  output ready);
endinterface

/* src/uart_bit_banged_transmitter.sv */
// The result of an accepted transaction is in the output register in the cycle after it is accepted.
// Throughput: one transaction per cycle; the input stays ready while the output register
//   is empty or is being drained in the same cycle.
// Reset (rst_ni, async, active low): idle, line high, counters and frame cleared,
//   bit period 0 (disabled), 8 data bits, no parity, output register empty.
`timescale 1ns / 1ps

module uart_bit_banged_transmitter #(
  parameter int unsigned PERIOD_WIDTH = 18
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  uart_tx_in_if.sink                             in_i,
  uart_tx_out_if.source                          out_o,
  input  logic                                   cfg_we_i,
  input  logic [uart_tx_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [PERIOD_WIDTH-1:0]                cfg_data_i
);

  localparam int unsigned FW = uart_tx_pkg::FrameWidth;
  localparam int unsigned CW = uart_tx_pkg::CountWidth;

  // Configuration registers
  logic [PERIOD_WIDTH-1:0]                    bit_period_q;
  logic [uart_tx_pkg::DataBitsWidth-1:0]      data_bits_q;
  logic [uart_tx_pkg::ParityWidth-1:0]        parity_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q  <= '0;
      data_bits_q   <= uart_tx_pkg::DATA_BITS_RESET;
      parity_mode_q <= uart_tx_pkg::PAR_NONE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        uart_tx_pkg::CFG_BIT_PERIOD:  bit_period_q  <= cfg_data_i;
        uart_tx_pkg::CFG_DATA_BITS:   data_bits_q   <= cfg_data_i[uart_tx_pkg::DataBitsWidth-1:0];
        uart_tx_pkg::CFG_PARITY_MODE: parity_mode_q <= cfg_data_i[uart_tx_pkg::ParityWidth-1:0];
        default: ;
      endcase
    end
  end

  // Transmit state
  logic [FW-1:0]           frame_q,  frame_d;
  logic [CW-1:0]           remain_q, remain_d;
  logic [PERIOD_WIDTH-1:0] count_q,  count_d;
  logic                    line_q,   line_d;
  logic                    busy_q,   busy_d;
  logic                    refused;

  // Output register
  logic out_valid_q;
  logic line_out_q, busy_out_q, refused_out_q;

  logic in_fire;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  // ---------------------------------------------------------------------------
  // Frame builder: start bit in bit 0, data LSB first, parity and stop placed
  // right after the last configured data bit.
  // ---------------------------------------------------------------------------
  logic [uart_tx_pkg::DataBitsWidth-1:0] nbits;
  logic [uart_tx_pkg::ByteWidth-1:0]     byte_mask;
  logic                                  has_par;
  logic                                  par_bit;
  logic [CW-1:0]                         par_pos;
  logic [CW-1:0]                         stop_pos;
  logic [FW-1:0]                         new_frame;

  always_comb begin
    if (data_bits_q < uart_tx_pkg::DATA_BITS_MIN) begin
      nbits = uart_tx_pkg::DATA_BITS_MIN;
    end else if (data_bits_q > uart_tx_pkg::DATA_BITS_MAX) begin
      nbits = uart_tx_pkg::DATA_BITS_MAX;
    end else begin
      nbits = data_bits_q;
    end

    case (nbits)
      4'd5:    byte_mask = 8'h1F;
      4'd6:    byte_mask = 8'h3F;
      4'd7:    byte_mask = 8'h7F;
      default: byte_mask = 8'hFF;
    endcase

    // parity always spans the full byte
    has_par = 1'b1;
    case (parity_mode_q)
      uart_tx_pkg::PAR_EVEN:  par_bit = ^in_i.tx_byte;
      uart_tx_pkg::PAR_ODD:   par_bit = ~(^in_i.tx_byte);
      uart_tx_pkg::PAR_MARK:  par_bit = 1'b1;
      uart_tx_pkg::PAR_SPACE: par_bit = 1'b0;
      default: begin
        par_bit = 1'b0;
        has_par = 1'b0;
      end
    endcase

    par_pos  = nbits + CW'(1);
    stop_pos = par_pos + CW'(has_par);

    new_frame = {2'b00, in_i.tx_byte & byte_mask, 1'b0};
    for (int i = 0; i < FW; i++) begin
      if (has_par && (CW'(i) == par_pos)) new_frame[i] = par_bit;
      if (CW'(i) == stop_pos)             new_frame[i] = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-transaction next state
  // ---------------------------------------------------------------------------
  logic [PERIOD_WIDTH-1:0] count_inc;
  assign count_inc = count_q + PERIOD_WIDTH'(1);

  always_comb begin
    frame_d  = frame_q;
    remain_d = remain_q;
    count_d  = count_q;
    line_d   = line_q;
    busy_d   = busy_q;
    refused  = 1'b0;

    if (in_i.action == uart_tx_pkg::ACT_LOAD) begin
      if (bit_period_q == '0 || busy_q) begin
        refused = 1'b1;
      end else begin
        // guard period: line stays high for one bit time
        frame_d  = new_frame;
        remain_d = stop_pos + CW'(1);
        count_d  = '0;
        busy_d   = 1'b1;
        line_d   = 1'b1;
      end
    end else if (busy_q) begin
      if (bit_period_q == '0) begin
        // disabled mid-frame: abort
        busy_d   = 1'b0;
        line_d   = 1'b1;
        count_d  = '0;
        remain_d = '0;
        frame_d  = '0;
      end else if (count_inc >= bit_period_q || count_inc == '0) begin
        count_d = '0;
        if (remain_q == '0) begin
          busy_d = 1'b0;
          line_d = 1'b1;
        end else begin
          line_d   = frame_q[0];
          frame_d  = {1'b0, frame_q[FW-1:1]};
          remain_d = remain_q - CW'(1);
        end
      end else begin
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q  <= '0;
      remain_q <= '0;
      count_q  <= '0;
      line_q   <= 1'b1;
      busy_q   <= 1'b0;
    end else if (in_fire) begin
      frame_q  <= frame_d;
      remain_q <= remain_d;
      count_q  <= count_d;
      line_q   <= line_d;
      busy_q   <= busy_d;
    end
  end

  // Result register: loaded with each accepted transaction, holds until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      line_out_q    <= line_d;
      busy_out_q    <= busy_d;
      refused_out_q <= refused;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.line_level   = line_out_q;
  assign out_o.busy_res     = busy_out_q;
  assign out_o.load_refused = refused_out_q;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned PeriodWidth   = 18;
  localparam logic [PeriodWidth-1:0] PeriodMax = '1;
  localparam logic [PeriodWidth-1:0] PeriodTop = 18'd200000;
  // index past the last register; the block must ignore writes to it
  localparam logic [uart_tx_pkg::CfgIndexWidth-1:0] CFG_UNUSED = 2'd3;

  localparam int unsigned RandomItems   = 450;
  localparam int unsigned HoldAfter     = 150;  // results seen before the long sink stall
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned WatchdogLimit = 2000; // cycles with no transaction and no register write
  localparam int unsigned DrainCycles   = 4;

  // One line status per transaction in, one transaction out
  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic load_refused;
  } tx_status_t;

  // Tracks the transmitter's state and configuration and holds the line
  // status each accepted transaction should produce, oldest first.
  class tx_scoreboard;
    logic [PeriodWidth-1:0]                bit_period;
    logic [uart_tx_pkg::DataBitsWidth-1:0] data_bits;
    logic [uart_tx_pkg::ParityWidth-1:0]   parity_mode;
    logic [uart_tx_pkg::FrameWidth-1:0]    frame_shift;
    logic [uart_tx_pkg::CountWidth-1:0]    bits_left;
    logic [PeriodWidth-1:0]                tick_count;
    logic                                  line_lvl;
    logic                                  sending;
    tx_status_t                            status_q[$];
    int unsigned                           errors;

    function new();
      bit_period  = '0;
      data_bits   = uart_tx_pkg::DATA_BITS_RESET;
      parity_mode = uart_tx_pkg::PAR_NONE;
      frame_shift = '0;
      bits_left   = '0;
      tick_count  = '0;
      line_lvl    = 1'b1;
      sending     = 1'b0;
      errors      = 0;
    endfunction

    function void write_reg(logic [uart_tx_pkg::CfgIndexWidth-1:0] idx,
                            logic [PeriodWidth-1:0] data);
      case (idx)
        uart_tx_pkg::CFG_BIT_PERIOD:  bit_period  = data;
        uart_tx_pkg::CFG_DATA_BITS:   data_bits   = data[uart_tx_pkg::DataBitsWidth-1:0];
        uart_tx_pkg::CFG_PARITY_MODE: parity_mode = data[uart_tx_pkg::ParityWidth-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(logic act, logic [uart_tx_pkg::ByteWidth-1:0] b);
      int unsigned nd;
      int unsigned pos;
      logic has_par;
      logic par;
      logic [PeriodWidth-1:0] nxt;
      tx_status_t st;
      st.load_refused = 1'b0;
      if (act == uart_tx_pkg::ACT_LOAD) begin
        if (bit_period == '0 || sending) begin
          st.load_refused = 1'b1;
        end else begin
          nd = 32'(data_bits);
          if (nd < 32'(uart_tx_pkg::DATA_BITS_MIN)) nd = 32'(uart_tx_pkg::DATA_BITS_MIN);
          if (nd > 32'(uart_tx_pkg::DATA_BITS_MAX)) nd = 32'(uart_tx_pkg::DATA_BITS_MAX);
          has_par = 1'b1;
          par     = 1'b0;
          // parity always spans the whole byte, even for short frames
          case (parity_mode)
            uart_tx_pkg::PAR_EVEN:  par = ^b;
            uart_tx_pkg::PAR_ODD:   par = ~^b;
            uart_tx_pkg::PAR_MARK:  par = 1'b1;
            uart_tx_pkg::PAR_SPACE: par = 1'b0;
            default:                has_par = 1'b0;
          endcase
          frame_shift = '0;  // bit 0 is the start bit
          for (int i = 0; i < nd; i++) frame_shift[i+1] = b[i];
          pos = nd + 1;
          if (has_par) begin
            frame_shift[pos] = par;
            pos++;
          end
          frame_shift[pos] = 1'b1;
          pos++;
          bits_left  = pos[uart_tx_pkg::CountWidth-1:0];
          tick_count = '0;
          sending    = 1'b1;
          line_lvl   = 1'b1;  // guard period
        end
      end else if (sending) begin
        if (bit_period == '0) begin
          // disabled mid-frame: abort
          sending     = 1'b0;
          line_lvl    = 1'b1;
          tick_count  = '0;
          bits_left   = '0;
          frame_shift = '0;
        end else begin
          nxt = tick_count + PeriodWidth'(1);
          if (nxt >= bit_period || nxt == '0) begin
            tick_count = '0;
            if (bits_left == '0) begin
              sending  = 1'b0;
              line_lvl = 1'b1;
            end else begin
              line_lvl    = frame_shift[0];
              frame_shift = frame_shift >> 1;
              bits_left--;
            end
          end else begin
            tick_count = nxt;
          end
        end
      end
      st.line_level = line_lvl;
      st.busy_res   = sending;
      status_q.push_back(st);
    endfunction

    function void check_result(tx_status_t got);
      tx_status_t want;
      if (status_q.size() == 0) begin
        $error("unexpected transaction out: line_level %0b busy_res %0b load_refused %0b",
               got.line_level, got.busy_res, got.load_refused);
        errors++;
        return;
      end
      want = status_q.pop_front();
      if (got.line_level !== want.line_level) begin
        $error("line_level: expected %0b, got %0b", want.line_level, got.line_level);
        errors++;
      end
      if (got.busy_res !== want.busy_res) begin
        $error("busy_res: expected %0b, got %0b", want.busy_res, got.busy_res);
        errors++;
      end
      if (got.load_refused !== want.load_refused) begin
        $error("load_refused: expected %0b, got %0b", want.load_refused, got.load_refused);
        errors++;
      end
    endfunction
  endclass

  logic                                  clk_i;
  logic                                  rst_ni;
  logic                                  cfg_we_i;
  logic [uart_tx_pkg::CfgIndexWidth-1:0] cfg_index_i;
  logic [PeriodWidth-1:0]                cfg_data_i;

  uart_tx_in_if  in_if ();
  uart_tx_out_if out_if ();

  uart_bit_banged_transmitter #(
    .PERIOD_WIDTH(PeriodWidth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  tx_scoreboard sb;
  int unsigned  results_seen;
  int unsigned  stall_cycles;
  int unsigned  items_sent;
  int unsigned  burst_left;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Everything driven to a known value from time zero
  initial begin
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.action  <= uart_tx_pkg::ACT_TICK;
    in_if.tx_byte <= '0;
    out_if.ready  <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= uart_tx_pkg::CFG_BIT_PERIOD;
    cfg_data_i    <= '0;
  end

  // Offer one transaction and hold it until the block takes it. The sender
  // runs in bursts; between bursts it may drop valid for a random gap.
  task automatic send_item(logic act, logic [uart_tx_pkg::ByteWidth-1:0] b);
    int unsigned gap;
    int unsigned r;
    cfg_we_i <= 1'b0;
    if (burst_left == 0) begin
      r = $urandom_range(0, 9);
      if (r < 4)      gap = 0;
      else if (r < 8) gap = $urandom_range(1, 3);
      else            gap = $urandom_range(4, 20);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid   <= 1'b1;
    in_if.action  <= act;
    in_if.tx_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_item(act, b);
    items_sent++;
  endtask

  // Register writes happen only once every outstanding transaction has come out.
  // Back-to-back writes keep the enable high; the next send lowers it.
  task automatic write_reg(logic [uart_tx_pkg::CfgIndexWidth-1:0] idx,
                           logic [PeriodWidth-1:0] data);
    in_if.valid <= 1'b0;
    while (sb.status_q.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Output monitor and watchdog. Sampling right at the edge sees the values
  // the block saw, before any of this edge's updates land.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        sb.check_result('{line_level:   out_if.line_level,
                          busy_res:     out_if.busy_res,
                          load_refused: out_if.load_refused});
        results_seen++;
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we_i)
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= WatchdogLimit) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // Sink: rotates through stall patterns, and once, after enough results,
  // stops taking anything for a long stretch so the output register fills
  // and the input backs up.
  initial begin : sink_side
    int unsigned rx_cycle;
    logic        held;
    rx_cycle = 0;
    held     = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (!held && results_seen >= HoldAfter) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        case ((rx_cycle / 64) % 4)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= ($urandom_range(0, 1) == 1);
          2:       out_if.ready <= (rx_cycle % 4 == 0);
          default: out_if.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [PeriodWidth-1:0]                cur_period;
    logic [uart_tx_pkg::DataBitsWidth-1:0] cur_bits;
    logic [uart_tx_pkg::ParityWidth-1:0]   cur_par;
    logic [PeriodWidth-1:0]                data;
    int unsigned nd;
    int unsigned frame_ticks;
    int unsigned nt;
    int unsigned r;

    sb           = new();
    results_seen = 0;
    stall_cycles = 0;
    items_sent   = 0;
    burst_left   = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed ---
    // write to a nonexistent register must change nothing
    write_reg(CFG_UNUSED, PeriodMax);
    // still disabled after reset: load refused; tick while idle does nothing
    send_item(uart_tx_pkg::ACT_LOAD, 8'hFF);
    send_item(uart_tx_pkg::ACT_TICK, 8'h00);

    // one full 8E1 frame at one tick per bit, with a load while busy
    write_reg(uart_tx_pkg::CFG_BIT_PERIOD, 18'd1);
    write_reg(uart_tx_pkg::CFG_DATA_BITS, PeriodWidth'(uart_tx_pkg::DATA_BITS_MAX));
    write_reg(uart_tx_pkg::CFG_PARITY_MODE, PeriodWidth'(uart_tx_pkg::PAR_EVEN));
    send_item(uart_tx_pkg::ACT_LOAD, 8'hA5);
    send_item(uart_tx_pkg::ACT_LOAD, 8'h5A);
    repeat (12) send_item(uart_tx_pkg::ACT_TICK, 8'hFF);

    // longest period, then disabled mid-frame: the frame aborts on the next tick
    write_reg(uart_tx_pkg::CFG_BIT_PERIOD, PeriodMax);
    write_reg(uart_tx_pkg::CFG_DATA_BITS, PeriodWidth'(uart_tx_pkg::DATA_BITS_MIN));
    write_reg(uart_tx_pkg::CFG_PARITY_MODE, PeriodWidth'(uart_tx_pkg::PAR_ODD));
    send_item(uart_tx_pkg::ACT_LOAD, 8'h00);
    repeat (2) send_item(uart_tx_pkg::ACT_TICK, 8'h00);
    write_reg(uart_tx_pkg::CFG_BIT_PERIOD, '0);
    send_item(uart_tx_pkg::ACT_TICK, 8'h00);

    // period lowered mid-bit: the current bit ends on the next tick
    write_reg(uart_tx_pkg::CFG_BIT_PERIOD, PeriodTop);
    write_reg(uart_tx_pkg::CFG_PARITY_MODE, PeriodWidth'(uart_tx_pkg::PAR_MARK));
    send_item(uart_tx_pkg::ACT_LOAD, 8'h3C);
    repeat (3) send_item(uart_tx_pkg::ACT_TICK, 8'h00);
    write_reg(uart_tx_pkg::CFG_BIT_PERIOD, 18'd1);
    repeat (2) send_item(uart_tx_pkg::ACT_TICK, 8'h00);

    cur_period = 18'd1;
    cur_bits   = uart_tx_pkg::DATA_BITS_MIN;
    cur_par    = uart_tx_pkg::PAR_MARK;

    // --- random phases: new settings, then whole frames with random bytes,
    // the odd truncated frame, stray loads while busy, and some noise ---
    while (items_sent < RandomItems) begin
      r = $urandom_range(0, 99);
      if (r < 8)       cur_period = '0;
      else if (r < 13) cur_period = $urandom_range(0, 1) ? PeriodTop : PeriodMax;
      else if (r < 75) cur_period = PeriodWidth'($urandom_range(1, 2));
      else             cur_period = PeriodWidth'($urandom_range(3, 5));
      write_reg(uart_tx_pkg::CFG_BIT_PERIOD, cur_period);

      if ($urandom_range(0, 2) != 0) begin
        data = PeriodWidth'($urandom);
        r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 8);
        data[uart_tx_pkg::DataBitsWidth-1:0] = r[uart_tx_pkg::DataBitsWidth-1:0];
        cur_bits = data[uart_tx_pkg::DataBitsWidth-1:0];
        write_reg(uart_tx_pkg::CFG_DATA_BITS, data);
      end
      if ($urandom_range(0, 2) != 0) begin
        data = PeriodWidth'($urandom);
        r = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
        data[uart_tx_pkg::ParityWidth-1:0] = r[uart_tx_pkg::ParityWidth-1:0];
        cur_par = data[uart_tx_pkg::ParityWidth-1:0];
        write_reg(uart_tx_pkg::CFG_PARITY_MODE, data);
      end
      if ($urandom_range(0, 9) == 0) write_reg(CFG_UNUSED, PeriodWidth'($urandom));

      nd = 32'(cur_bits);
      if (nd < 32'(uart_tx_pkg::DATA_BITS_MIN)) nd = 32'(uart_tx_pkg::DATA_BITS_MIN);
      if (nd > 32'(uart_tx_pkg::DATA_BITS_MAX)) nd = 32'(uart_tx_pkg::DATA_BITS_MAX);
      // guard + start + data + parity + stop; the frame ends when the stop
      // bit's period runs out
      frame_ticks = (nd + 3 + ((cur_par >= uart_tx_pkg::PAR_EVEN &&
                                cur_par <= uart_tx_pkg::PAR_SPACE) ? 1 : 0))
                    * ((cur_period == '0) ? 1 : 32'(cur_period));
      if (cur_period > 100) frame_ticks = $urandom_range(1, 15);

      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, 4)) begin
            r = $urandom;
            send_item(r[8], r[uart_tx_pkg::ByteWidth-1:0]);
          end
        r = $urandom;
        send_item(uart_tx_pkg::ACT_LOAD, r[uart_tx_pkg::ByteWidth-1:0]);
        nt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, frame_ticks)
                                         : frame_ticks + $urandom_range(0, 3);
        repeat (nt) begin
          r = $urandom;
          if ($urandom_range(0, 19) == 0)
            send_item(uart_tx_pkg::ACT_LOAD, r[uart_tx_pkg::ByteWidth-1:0]);
          else
            send_item(uart_tx_pkg::ACT_TICK, r[uart_tx_pkg::ByteWidth-1:0]);
        end
      end
    end

    // drain: wait for every expected transaction to come out
    in_if.valid <= 1'b0;
    while (sb.status_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.status_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
src/uart_tx_pkg.sv
src/uart_tx_in_if.sv
src/uart_tx_out_if.sv
src/uart_bit_banged_transmitter.sv
tb/tb_top.sv
